// ----- hw/rtl/plipt_pkg.sv -----
// Shared widths, register indexes and item types of the plane/line intersector.
`default_nettype none
package plipt_pkg;

   localparam int CW = 32;            // coordinate width
   localparam int FB = 16;            // fraction bits
   localparam int VW = CW + 1;        // direction width (difference of two coordinates)
   localparam int PW = CW + VW;       // one product n*v or n*p
   localparam int NW = PW + 3;        // sum of up to four terms, then negated
   localparam int AW = NW;            // magnitude of numerator or denominator
   localparam int RW = AW + CW;       // divider remainder
   localparam int OW = PW - FB + 1;   // coordinate before clamping
   localparam int EW = 32;            // epsilon register width
   localparam int IW = 3;             // register index width
   localparam int QD = 4;             // queue depth
   localparam int QA = $clog2(QD);

   typedef enum logic [IW-1:0] {
      REG_NORMAL_A = 3'd0,
      REG_NORMAL_B = 3'd1,
      REG_NORMAL_C = 3'd2,
      REG_OFFSET_D = 3'd3,
      REG_EPSILON  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [CW-1:0] a;
      logic [CW-1:0] b;
      logic [CW-1:0] c;
      logic [CW-1:0] d;
      logic [EW-1:0] eps;
   } plane_type;

   typedef struct packed {
      logic                seg;
      logic [2:0][CW-1:0]  p;
      logic [2:0][VW-1:0]  v;
   } geom_type;

   typedef struct packed {
      logic                nohit;
      logic                ovf;
      logic                tneg;
      logic [AW-1:0]       ad;
      logic [AW-1:0]       an;
      geom_type            geom;
   } item_type;

endpackage
`default_nettype wire

// ----- hw/rtl/plipt_front.sv -----
// Front pipeline: forms direction, dot products, and classifies each request.
`default_nettype none
module plipt_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire plipt_pkg::plane_type      plane,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic                      req_command,
   input  wire logic [plipt_pkg::CW-1:0]  req_start_x,
   input  wire logic [plipt_pkg::CW-1:0]  req_start_y,
   input  wire logic [plipt_pkg::CW-1:0]  req_start_z,
   input  wire logic [plipt_pkg::CW-1:0]  req_second_x,
   input  wire logic [plipt_pkg::CW-1:0]  req_second_y,
   input  wire logic [plipt_pkg::CW-1:0]  req_second_z,
   input  wire logic                      q_full,
   output logic                           push,
   output plipt_pkg::item_type            push_item
);
   import plipt_pkg::*;

   logic en;

   logic               s1_valid_ff;
   geom_type           s1_geom_ff, s1_geom_in;
   logic               s2_valid_ff;
   geom_type           s2_geom_ff;
   logic [2:0][PW-1:0] s2_dn_ff, s2_dn_in, s2_pn_ff, s2_pn_in;
   logic               s3_valid_ff;
   geom_type           s3_geom_ff;
   logic [NW-1:0]      s3_den_ff, s3_den_in, s3_num_ff, s3_num_in;
   logic               s4_valid_ff;
   geom_type           s4_geom_ff;
   logic [AW-1:0]      s4_ad_ff, s4_ad_in, s4_an_ff, s4_an_in;
   logic               s4_tneg_ff, s4_tneg_in;
   logic               s5_valid_ff;
   item_type           s5_item_ff, s5_item_in;
   logic [2:0][CW-1:0] start, second, nvec;
   logic [AW+CW-FB-1:0] an_ext, ad_ext;

   // Hold the whole front while the last stage cannot enter the queue.
   assign en        = !(s5_valid_ff && q_full);
   assign req_stall = !en;
   assign push      = s5_valid_ff && !q_full;
   assign push_item = s5_item_ff;

   assign start  = {req_start_z, req_start_y, req_start_x};
   assign second = {req_second_z, req_second_y, req_second_x};
   assign nvec   = {plane.c, plane.b, plane.a};

   always_comb begin
      s1_geom_in.seg = req_command;
      s1_geom_in.p   = start;
      for (int i = 0; i < 3; i++) begin
         if (req_command) begin
            s1_geom_in.v[i] = VW'($signed(second[i])) - VW'($signed(start[i]));
         end else begin
            s1_geom_in.v[i] = VW'($signed(second[i]));
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s2_dn_in[i] = PW'($signed(nvec[i])) * PW'($signed(s1_geom_ff.v[i]));
         s2_pn_in[i] = PW'($signed(nvec[i])) * PW'($signed(s1_geom_ff.p[i]));
      end
   end

   always_comb begin
      s3_den_in = NW'($signed(s2_dn_ff[0])) + NW'($signed(s2_dn_ff[1]))
                + NW'($signed(s2_dn_ff[2]));
      s3_num_in = -(NW'($signed(s2_pn_ff[0])) + NW'($signed(s2_pn_ff[1]))
                + NW'($signed(s2_pn_ff[2])) + (NW'($signed(plane.d)) <<< FB));
   end

   always_comb begin
      s4_ad_in   = s3_den_ff[NW-1] ? AW'(-s3_den_ff) : AW'(s3_den_ff);
      s4_an_in   = s3_num_ff[NW-1] ? AW'(-s3_num_ff) : AW'(s3_num_ff);
      s4_tneg_in = (s3_num_ff != '0) && (s3_num_ff[NW-1] != s3_den_ff[NW-1]);
   end

   assign an_ext = (AW+CW-FB)'(s4_an_ff);
   assign ad_ext = (AW+CW-FB)'(s4_ad_ff) << (CW - FB);

   always_comb begin
      s5_item_in.geom  = s4_geom_ff;
      s5_item_in.ad    = s4_ad_ff;
      s5_item_in.an    = s4_an_ff;
      s5_item_in.tneg  = s4_tneg_ff;
      s5_item_in.nohit = (s4_ad_ff <= AW'(plane.eps))
                       || (s4_geom_ff.seg && (s4_tneg_ff || (s4_an_ff > s4_ad_ff)));
      s5_item_in.ovf   = an_ext >= ad_ext;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_geom_ff <= s1_geom_in;
         s2_geom_ff <= s1_geom_ff;
         s2_dn_ff   <= s2_dn_in;
         s2_pn_ff   <= s2_pn_in;
         s3_geom_ff <= s2_geom_ff;
         s3_den_ff  <= s3_den_in;
         s3_num_ff  <= s3_num_in;
         s4_geom_ff <= s3_geom_ff;
         s4_ad_ff   <= s4_ad_in;
         s4_an_ff   <= s4_an_in;
         s4_tneg_ff <= s4_tneg_in;
         s5_item_ff <= s5_item_in;
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/plipt_queue.sv -----
// Short request queue between the classifying front and the dividing back.
`default_nettype none
module plipt_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire plipt_pkg::item_type  push_item,
   output logic                      full,
   input  wire logic                 pop,
   output logic                      empty,
   output plipt_pkg::item_type       head
);
   import plipt_pkg::*;

   item_type        mem_ff [QD];
   logic [QA-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QA:0]     count_ff;
   logic            do_push, do_pop;

   assign full    = count_ff == (QA+1)'(QD);
   assign empty   = count_ff == '0;
   assign head    = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (do_push && !do_pop) count_ff <= count_ff + 1'b1;
         else if (do_pop && !do_push) count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_item;
   end

endmodule
`default_nettype wire

// ----- hw/rtl/plipt_back.sv -----
// Back pipeline: one quotient bit per stage, then t clamp, scaling and saturation.
`default_nettype none
module plipt_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      q_empty,
   input  wire plipt_pkg::item_type       head,
   output logic                           pop,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic                           rsp_hit,
   output logic [plipt_pkg::CW-1:0]       rsp_point_x,
   output logic [plipt_pkg::CW-1:0]       rsp_point_y,
   output logic [plipt_pkg::CW-1:0]       rsp_point_z,
   output logic                           rsp_saturated
);
   import plipt_pkg::*;

   logic en;

   logic            div_valid_ff [CW+1];
   item_type        div_item_ff  [CW+1];
   logic [RW-1:0]   div_rem_ff   [CW+1];
   logic [CW-1:0]   div_quo_ff   [CW+1];

   logic               f1_valid_ff;
   logic               f1_hit_ff, f1_hit_in;
   logic               f1_sat_ff, f1_sat_in;
   logic [2:0][PW-1:0] f1_prod_ff, f1_prod_in;
   logic [2:0][CW-1:0] f1_p_ff;
   logic [CW-1:0]      lim, qc, t;

   logic               out_valid_ff;
   logic               out_hit_ff, out_sat_ff, out_sat_in;
   logic [2:0][CW-1:0] out_pt_ff, out_pt_in;
   logic [2:0]         coord_sat;

   // Advance while the output register is empty or being taken.
   assign en  = !out_valid_ff || !rsp_stall;
   assign pop = en && !q_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         div_valid_ff[0] <= 1'b0;
      end else if (en) begin
         div_valid_ff[0] <= !q_empty;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         div_item_ff[0] <= head;
         div_rem_ff[0]  <= RW'(head.an) << FB;
         div_quo_ff[0]  <= '0;
      end
   end

   for (genvar k = 0; k < CW; k++) begin : g_div
      localparam int SH = CW - 1 - k;
      logic [RW-1:0] dsh;
      logic          ge;

      assign dsh = RW'(div_item_ff[k].ad) << SH;
      assign ge  = div_rem_ff[k] >= dsh;

      always_ff @(posedge clock) begin
         if (reset) begin
            div_valid_ff[k+1] <= 1'b0;
         end else if (en) begin
            div_valid_ff[k+1] <= div_valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            div_item_ff[k+1] <= div_item_ff[k];
            div_rem_ff[k+1]  <= ge ? div_rem_ff[k] - dsh : div_rem_ff[k];
            div_quo_ff[k+1]  <= {div_quo_ff[k][CW-2:0], ge};
         end
      end
   end

   // Clamp the quotient to the signed range and apply the sign of t.
   always_comb begin
      lim = div_item_ff[CW].tneg ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      f1_sat_in = div_item_ff[CW].ovf || (div_quo_ff[CW] > lim);
      qc = f1_sat_in ? lim : div_quo_ff[CW];
      t  = div_item_ff[CW].tneg ? -qc : qc;
      f1_hit_in = !div_item_ff[CW].nohit;
      for (int i = 0; i < 3; i++) begin
         f1_prod_in[i] = PW'($signed(div_item_ff[CW].geom.v[i])) * PW'($signed(t));
      end
   end

   always_comb begin
      logic [OW-1:0] r;
      for (int i = 0; i < 3; i++) begin
         r = OW'($signed(f1_prod_ff[i]) >>> FB) + OW'($signed(f1_p_ff[i]));
         if (r[OW-1:CW-1] == '0 || r[OW-1:CW-1] == '1) begin
            out_pt_in[i] = r[CW-1:0];
            coord_sat[i] = 1'b0;
         end else begin
            out_pt_in[i] = r[OW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
            coord_sat[i] = 1'b1;
         end
         if (!f1_hit_ff) begin
            out_pt_in[i] = '0;
         end
      end
      out_sat_in = f1_hit_ff && (f1_sat_ff || (coord_sat != '0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         f1_valid_ff  <= div_valid_ff[CW];
         out_valid_ff <= f1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f1_hit_ff  <= f1_hit_in;
         f1_sat_ff  <= f1_sat_in;
         f1_prod_ff <= f1_prod_in;
         f1_p_ff    <= div_item_ff[CW].geom.p;
         out_hit_ff <= f1_hit_ff;
         out_sat_ff <= out_sat_in;
         out_pt_ff  <= out_pt_in;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_hit       = out_hit_ff;
   assign rsp_point_x   = out_pt_ff[0];
   assign rsp_point_y   = out_pt_ff[1];
   assign rsp_point_z   = out_pt_ff[2];
   assign rsp_saturated = out_sat_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/plane_line_intersect.sv -----
// Top level of the plane/line intersector: plane registers, front, queue and back.
//
// Usage: program the plane A, B, C, D (signed Q16.16) and the parallel
// epsilon through the csr_ write port while the block is idle, then stream
// requests on the req_ channel. Each request is a ray (start point plus
// direction) or a segment (two endpoints); it yields exactly one response
// on the rsp_ channel, in order: hit flag, intersection point and a flag
// that tells whether t or a coordinate was clamped.
// Throughput: one request per cycle when nothing stalls. A request passes
// through the 5-stage front, one queue slot and the 32-stage pipelined
// divider that yields one quotient bit per stage, followed by the
// scaling multiply and the output register.
// Reset clears the pipelines and the queue and loads the plane registers
// with the plane z = 0 and an epsilon of one.
// When the receiver raises rsp_stall the back pipeline holds; the front
// keeps accepting until the 4-entry queue fills, then raises req_stall.
`default_nettype none
module plane_line_intersect (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_write,
   input  wire logic [plipt_pkg::IW-1:0]  csr_index,
   input  wire logic [plipt_pkg::EW-1:0]  csr_wdata,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic                      req_command,
   input  wire logic [plipt_pkg::CW-1:0]  req_start_x,
   input  wire logic [plipt_pkg::CW-1:0]  req_start_y,
   input  wire logic [plipt_pkg::CW-1:0]  req_start_z,
   input  wire logic [plipt_pkg::CW-1:0]  req_second_x,
   input  wire logic [plipt_pkg::CW-1:0]  req_second_y,
   input  wire logic [plipt_pkg::CW-1:0]  req_second_z,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic                           rsp_hit,
   output logic [plipt_pkg::CW-1:0]       rsp_point_x,
   output logic [plipt_pkg::CW-1:0]       rsp_point_y,
   output logic [plipt_pkg::CW-1:0]       rsp_point_z,
   output logic                           rsp_saturated
);
   import plipt_pkg::*;

   plane_type plane_ff;
   logic      q_full, q_empty, push, pop;
   item_type  push_item, head;

   // Plane registers: load on write, drop writes to unknown indexes.
   always_ff @(posedge clock) begin
      if (reset) begin
         plane_ff.a   <= '0;
         plane_ff.b   <= '0;
         plane_ff.c   <= CW'(1) << FB;
         plane_ff.d   <= '0;
         plane_ff.eps <= EW'(1);
      end else if (csr_write) begin
         case (csr_index)
            REG_NORMAL_A: plane_ff.a   <= CW'(csr_wdata);
            REG_NORMAL_B: plane_ff.b   <= CW'(csr_wdata);
            REG_NORMAL_C: plane_ff.c   <= CW'(csr_wdata);
            REG_OFFSET_D: plane_ff.d   <= CW'(csr_wdata);
            REG_EPSILON:  plane_ff.eps <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Front: direction, dot products, parallel and segment-range tests.
   plipt_front u_front (
      .clock        (clock),
      .reset        (reset),
      .plane        (plane_ff),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_command  (req_command),
      .req_start_x  (req_start_x),
      .req_start_y  (req_start_y),
      .req_start_z  (req_start_z),
      .req_second_x (req_second_x),
      .req_second_y (req_second_y),
      .req_second_z (req_second_z),
      .q_full       (q_full),
      .push         (push),
      .push_item    (push_item)
   );

   // Queue: decouple front stalls from back stalls.
   plipt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (pop),
      .empty     (q_empty),
      .head      (head)
   );

   // Back: divide for t, clamp, scale the direction and add the start.
   plipt_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .head          (head),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_hit       (rsp_hit),
      .rsp_point_x   (rsp_point_x),
      .rsp_point_y   (rsp_point_y),
      .rsp_point_z   (rsp_point_z),
      .rsp_saturated (rsp_saturated)
   );

endmodule
`default_nettype wire

// ----- verif/tb_plane_line_intersect.sv -----
// Self-checking testbench for the plane/line intersector: directed table, then random streams.
`timescale 1ns / 100ps
`default_nettype none
module tb_plane_line_intersect;
   import plipt_pkg::*;

   localparam logic [CW-1:0] ONE     = 32'h0001_0000;   // 1.0 in Q16.16
   localparam logic [CW-1:0] NEG_ONE = 32'hFFFF_0000;
   localparam logic [CW-1:0] MAX_C   = 32'h7FFF_FFFF;
   localparam logic [CW-1:0] MIN_C   = 32'h8000_0000;
   localparam logic [IW-1:0] REG_SPARE = 3'd7;          // no register behind this index
   localparam logic          CMD_RAY = 1'b0;
   localparam logic          CMD_SEG = 1'b1;
   localparam int            LATENCY = 40;
   localparam int            CYCLE_LIMIT = 600000;

   typedef struct packed {
      logic                cmd;
      logic [2:0][CW-1:0]  start;
      logic [2:0][CW-1:0]  second;
   } line_req_type;

   typedef struct packed {
      logic                hit;
      logic [2:0][CW-1:0]  point;
      logic                sat;
   } hit_rsp_type;

   typedef struct {
      line_req_type  rq;
      bit            typed;     // expected response given in the table
      hit_rsp_type   want;
   } table_row_type;

   logic           clock = 1'b0;
   logic           reset = 1'b1;
   logic           csr_write = 1'b0;
   logic [IW-1:0]  csr_index = '0;
   logic [EW-1:0]  csr_wdata = '0;
   logic           req_valid = 1'b0;
   logic           req_stall;
   logic           req_command = 1'b0;
   logic [CW-1:0]  req_start_x = '0, req_start_y = '0, req_start_z = '0;
   logic [CW-1:0]  req_second_x = '0, req_second_y = '0, req_second_z = '0;
   logic           rsp_valid;
   logic           rsp_stall = 1'b0;
   logic           rsp_hit;
   logic [CW-1:0]  rsp_point_x, rsp_point_y, rsp_point_z;
   logic           rsp_saturated;

   plane_line_intersect dut (.*);

   always #4 clock = ~clock;

   // Shadow copy of the plane registers, updated on every csr write.
   longint plane_a, plane_b, plane_c, plane_d;
   longint unsigned plane_eps;

   hit_rsp_type pending_hits[$];
   int       send_idle_pct = 0;
   int       stall_pct = 0;
   int       errors = 0;
   int       n_requests = 0, n_responses = 0, n_hits = 0, n_sats = 0;
   int       cycles = 0;

   // Exact intersection, everything widened to 128 bits.
   function automatic hit_rsp_type predict(line_req_type r);
      logic signed [127:0] nrm[3], p[3], v[3];
      logic signed [127:0] den, num, ad, an, q, lim, t, rr, eps, cmax, cmin;
      bit tneg, sat;
      hit_rsp_type o;
      o = '0;
      nrm[0] = plane_a; nrm[1] = plane_b; nrm[2] = plane_c;
      den = 0; num = 0; sat = 0;
      cmax = 128'sh7FFF_FFFF;
      cmin = -cmax - 1;
      for (int i = 0; i < 3; i++) begin
         p[i] = longint'($signed(r.start[i]));
         v[i] = longint'($signed(r.second[i]));
         if (r.cmd == CMD_SEG) v[i] = v[i] - p[i];
         den = den + nrm[i] * v[i];
         num = num + nrm[i] * p[i];
      end
      rr = plane_d;
      num = -(num + (rr <<< FB));
      ad = den < 0 ? -den : den;
      an = num < 0 ? -num : num;
      eps = {64'd0, plane_eps};
      if (ad <= eps) return o;
      tneg = (num != 0) && ((num < 0) != (den < 0));
      if (r.cmd == CMD_SEG && (tneg || an > ad)) return o;
      q = (an <<< FB) / ad;
      lim = tneg ? cmax + 1 : cmax;
      if (q > lim) begin
         q = lim;
         sat = 1;
      end
      t = tneg ? -q : q;
      for (int i = 0; i < 3; i++) begin
         rr = ((v[i] * t) >>> FB) + p[i];
         if (rr > cmax) begin
            rr = cmax;
            sat = 1;
         end else if (rr < cmin) begin
            rr = cmin;
            sat = 1;
         end
         o.point[i] = rr[CW-1:0];
      end
      o.hit = 1;
      o.sat = sat;
      return o;
   endfunction

   function automatic line_req_type mk_line(logic cmd, logic [CW-1:0] sx, sy, sz, qx, qy, qz);
      line_req_type r;
      r.cmd = cmd;
      r.start[0] = sx; r.start[1] = sy; r.start[2] = sz;
      r.second[0] = qx; r.second[1] = qy; r.second[2] = qz;
      return r;
   endfunction

   function automatic hit_rsp_type mk_hit(logic h, logic [CW-1:0] x, y, z, logic s);
      hit_rsp_type o;
      o.hit = h; o.point[0] = x; o.point[1] = y; o.point[2] = z; o.sat = s;
      return o;
   endfunction

   // Coordinate with mostly moderate magnitude, some full-range and corner values.
   function automatic logic [CW-1:0] pick_coord(int bits);
      int k;
      k = $urandom_range(99);
      if (k < 10) return $urandom;
      if (k < 18) begin
         case ($urandom_range(3))
            0: return MIN_C;
            1: return MAX_C;
            2: return '0;
            default: return '1;
         endcase
      end
      return $signed($urandom) >>> (32 - bits);
   endfunction

   task automatic write_reg(logic [IW-1:0] idx, logic [EW-1:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         REG_NORMAL_A: plane_a = longint'($signed(val));
         REG_NORMAL_B: plane_b = longint'($signed(val));
         REG_NORMAL_C: plane_c = longint'($signed(val));
         REG_OFFSET_D: plane_d = longint'($signed(val));
         REG_EPSILON:  plane_eps = val;
         default: ;
      endcase
   endtask

   task automatic set_plane(logic [CW-1:0] a, b, c, d, logic [EW-1:0] eps);
      write_reg(REG_NORMAL_A, a);
      write_reg(REG_NORMAL_B, b);
      write_reg(REG_NORMAL_C, c);
      write_reg(REG_OFFSET_D, d);
      write_reg(REG_EPSILON, eps);
      write_reg(REG_SPARE, $urandom);   // ignored by the block
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   // Hold off until every pending response has come back, then let the pipe settle.
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_hits.size() != 0) @(posedge clock);
      repeat (LATENCY + 20) @(posedge clock);
   endtask

   // Present one request; optional idle gap first, then hold until accepted.
   task automatic send_line(line_req_type r, bit typed, hit_rsp_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_command  <= r.cmd;
      req_start_x  <= r.start[0];
      req_start_y  <= r.start[1];
      req_start_z  <= r.start[2];
      req_second_x <= r.second[0];
      req_second_y <= r.second[1];
      req_second_z <= r.second[2];
      do @(posedge clock); while (req_stall);
      pending_hits.push_back(typed ? want : predict(r));
      n_requests++;
   endtask

   task automatic random_stream(int count);
      line_req_type r;
      int bits;
      for (int i = 0; i < count; i++) begin
         bits = $urandom_range(10, 26);
         r.cmd = $urandom_range(1);
         for (int j = 0; j < 3; j++) begin
            r.start[j]  = pick_coord(bits);
            r.second[j] = pick_coord(bits);
         end
         send_line(r, 0, '0);
      end
   endtask

   // Run the four idling patterns against the current plane.
   task automatic idle_sweep(int count);
      send_idle_pct = 0;  stall_pct = 0;  random_stream(count);
      send_idle_pct = 85; stall_pct = 0;  random_stream(count);
      send_idle_pct = 0;  stall_pct = 85; random_stream(count);
      send_idle_pct = 16; stall_pct = 16; random_stream(count);
      send_idle_pct = 0;  stall_pct = 0;
      drain();
   endtask

   // Response side: random stall, compare every accepted response in order.
   always @(posedge clock) begin
      hit_rsp_type got, exp_hit;
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t timeout with %0d responses outstanding", $time, pending_hits.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         got = mk_hit(rsp_hit, rsp_point_x, rsp_point_y, rsp_point_z, rsp_saturated);
         n_responses++;
         if (pending_hits.size() == 0) begin
            errors++;
            $display("%0t unexpected response got=%h", $time, got);
         end else begin
            exp_hit = pending_hits.pop_front();
            if (got.hit != exp_hit.hit) begin
               errors++;
               $display("%0t hit exp=%b got=%b", $time, exp_hit.hit, got.hit);
            end
            for (int i = 0; i < 3; i++)
               if (got.point[i] != exp_hit.point[i]) begin
                  errors++;
                  $display("%0t point[%0d] exp=%h got=%h", $time, i,
                           exp_hit.point[i], got.point[i]);
               end
            if (got.sat != exp_hit.sat) begin
               errors++;
               $display("%0t saturated exp=%b got=%b", $time, exp_hit.sat, got.sat);
            end
            n_hits += got.hit;
            n_sats += got.sat;
         end
      end
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   table_row_type lines[$];

   initial begin
      // Reset state: plane z = 0, epsilon of one.
      plane_a = 0; plane_b = 0; plane_c = 65536; plane_d = 0; plane_eps = 1;

      // Ray from z=2 straight down lands on the origin.
      lines.push_back('{mk_line(CMD_RAY, 0, 0, 2*ONE, 0, 0, NEG_ONE), 1,
                        mk_hit(1, 0, 0, 0, 0)});
      // Zero direction: no hit.
      lines.push_back('{mk_line(CMD_RAY, ONE, ONE, ONE, 0, 0, 0), 1, '0});
      // Direction parallel to the plane.
      lines.push_back('{mk_line(CMD_RAY, 0, 0, ONE, ONE, 0, 0), 1, '0});
      // Segment with equal endpoints.
      lines.push_back('{mk_line(CMD_SEG, ONE, 2*ONE, 3*ONE, ONE, 2*ONE, 3*ONE), 1, '0});
      // Segment crossing at its midpoint.
      lines.push_back('{mk_line(CMD_SEG, 0, 0, ONE, 0, 0, NEG_ONE), 1,
                        mk_hit(1, 0, 0, 0, 0)});
      // Segment moving away from the plane: t below zero.
      lines.push_back('{mk_line(CMD_SEG, 0, 0, ONE, 0, 0, 2*ONE), 1, '0});
      // Segment stopping short: t above one.
      lines.push_back('{mk_line(CMD_SEG, 0, 0, 3*ONE, 0, 0, 2*ONE), 1, '0});
      // Ray pointing away still hits behind its start.
      lines.push_back('{mk_line(CMD_RAY, 0, 0, ONE, 0, 0, ONE), 0, '0});
      // Tiny direction: t clamps.
      lines.push_back('{mk_line(CMD_RAY, 0, 0, MAX_C, 0, 0, '1), 0, '0});
      lines.push_back('{mk_line(CMD_RAY, MAX_C, MIN_C, MAX_C, 0, ONE, 1), 0, '0});
      // Corner coordinates in both modes.
      lines.push_back('{mk_line(CMD_RAY, MIN_C, MIN_C, MIN_C, MAX_C, MAX_C, MAX_C), 0, '0});
      lines.push_back('{mk_line(CMD_SEG, MIN_C, MIN_C, MIN_C, MAX_C, MAX_C, MAX_C), 0, '0});
      lines.push_back('{mk_line(CMD_SEG, MAX_C, MAX_C, MAX_C, MIN_C, MIN_C, MIN_C), 0, '0});
      lines.push_back('{mk_line(CMD_RAY, MAX_C, MAX_C, MAX_C, MIN_C, MIN_C, MIN_C), 0, '0});
      // Endpoint exactly on the plane, and a start on the plane.
      lines.push_back('{mk_line(CMD_SEG, 5*ONE, 0, ONE, 5*ONE, 0, 0), 0, '0});
      lines.push_back('{mk_line(CMD_RAY, 3*ONE, 4*ONE, 0, ONE, ONE, ONE), 0, '0});

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (lines[i]) send_line(lines[i].rq, lines[i].typed, lines[i].want);
      drain();

      // Tilted planes, epsilon at zero and at its top, then corner coefficients.
      set_plane(ONE, NEG_ONE, 2*ONE, 32'hFFF8_0000, 0);
      foreach (lines[i]) send_line(lines[i].rq, 0, '0);
      idle_sweep(92);

      set_plane(pick_coord(20), pick_coord(20), pick_coord(20), pick_coord(24), $urandom_range(255));
      idle_sweep(92);

      // Pause the sender until everything is back, mid-phase.
      random_stream(40);
      drain();
      random_stream(40);
      drain();

      set_plane(MIN_C, MAX_C, '1, MIN_C, '1);
      idle_sweep(46);

      set_plane(MAX_C, 0, MIN_C, MAX_C, 0);
      idle_sweep(46);

      set_plane($urandom, $urandom, $urandom, $urandom, $urandom);
      idle_sweep(46);

      set_plane(0, 0, ONE, 0, 1);
      idle_sweep(92);

      $display("%0d requests, %0d responses: %0d hits, %0d clamped, reset plane plus six more",
               n_requests, n_responses, n_hits, n_sats);
      $display("rays and segments under four idle/stall patterns");
      if (errors == 0 && pending_hits.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ----- plane_line_intersect.f -----
hw/rtl/plipt_pkg.sv
hw/rtl/plipt_front.sv
hw/rtl/plipt_queue.sv
hw/rtl/plipt_back.sv
hw/rtl/plane_line_intersect.sv
verif/tb_plane_line_intersect.sv
